// ===== sv/hcalu_pkg.sv =====
package hcalu_pkg;

  // operation codes; 29 to 31 are unused and act as a no-op
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_DAA  = 5'd10,
    OP_CPL  = 5'd11,
    OP_SCF  = 5'd12,
    OP_CCF  = 5'd13,
    OP_RLCA = 5'd14,
    OP_RRCA = 5'd15,
    OP_RLA  = 5'd16,
    OP_RRA  = 5'd17,
    OP_RLC  = 5'd18,
    OP_RRC  = 5'd19,
    OP_RL   = 5'd20,
    OP_RR   = 5'd21,
    OP_SLA  = 5'd22,
    OP_SRA  = 5'd23,
    OP_SWAP = 5'd24,
    OP_SRL  = 5'd25,
    OP_BIT  = 5'd26,
    OP_RES  = 5'd27,
    OP_SET  = 5'd28
  } op_t;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // decimal adjust constants
  localparam logic [7:0] DAA_ADJ_LO = 8'h06;
  localparam logic [7:0] DAA_ADJ_HI = 8'h60;
  localparam logic [7:0] DAA_LIMIT  = 8'h99;
  localparam logic [3:0] DAA_NIB_MAX = 4'h9;

  typedef struct packed {
    logic [4:0] op;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [2:0] bit_index;
    logic [3:0] flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       write_result;
  } alu_out_t;

endpackage

// ===== sv/handheld_cpu_alu_8bit_top.sv =====
// 8-bit handheld cpu alu with z/n/h/c flags
//
// input channel: in_valid / in_data / in_stall carries one operation per
// transaction (op code, two operand bytes, bit index, incoming flags).
// output channel: out_valid / out_data / out_stall returns one result per
// transaction: result byte, new flags and the write-back enable.
//
// the operation is latched into the input register when accepted, decoded
// and computed by one pass of 8-bit add/shift logic, and captured in the
// output register when that register is empty or being read out.
// throughput: one transaction per cycle, sustained, as long as out_stall
// stays low.
//
// when the receiver stalls, the output register holds its transaction and
// the input register still takes one more; in_stall rises only when both
// registers are full and out_stall is high.
// reset clears both valid flags; no transaction is in flight afterwards.
module handheld_cpu_alu_8bit_top
  import hcalu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  alu_in_t  in_data,
  output logic     in_stall,
  output logic     out_valid,
  output alu_out_t out_data,
  input  logic     out_stall
);

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  alu_in_t  s1_data_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  alu_out_t out_data_r;
  alu_out_t core_out;
  logic     out_en;
  logic     s1_en;

  // stage enables
  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;

  assign s1_valid_nxt  = s1_en ? in_valid : s1_valid_r;
  assign out_valid_nxt = out_en ? s1_valid_r : out_valid_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_data_r <= in_data;
    end
  end

  // alu datapath
  hcalu_core u_core (
    .alu_in  (s1_data_r),
    .alu_out (core_out)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data_r <= core_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // stall only when both registers hold a transaction
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  // a pending transaction moves into an empty result register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("transaction did not advance to result register");

  // an accepted transaction always lands in the input register
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted transaction lost");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");
`endif

endmodule

// ===== sv/hcalu_core.sv =====
module hcalu_core
  import hcalu_pkg::*;
(
  input  alu_in_t  alu_in,
  output alu_out_t alu_out
);

  logic [7:0] a;
  logic [7:0] b;
  logic [3:0] fl;
  logic       cin;
  logic       nin;
  logic       hin;
  logic       zin;
  logic       carry_t;
  logic       sub_t;
  logic [8:0] sum9;
  logic [4:0] sum_half;
  logic [8:0] diff9;
  logic [4:0] diff_half;
  logic [7:0] inc_r;
  logic [7:0] dec_r;
  logic [7:0] daa_adj;
  logic       daa_c;
  logic [7:0] daa_r;
  logic [7:0] bit_mask;
  logic [7:0] res;
  logic [3:0] flg;
  logic       wr;

  assign a   = alu_in.operand_a;
  assign b   = alu_in.operand_b;
  assign fl  = alu_in.flags_in;
  assign cin = fl[FLAG_C];
  assign nin = fl[FLAG_N];
  assign hin = fl[FLAG_H];
  assign zin = fl[FLAG_Z];

  // adder and subtractor with half-carry and borrow
  assign carry_t   = (alu_in.op == OP_ADC) ? cin : 1'b0;
  assign sub_t     = (alu_in.op == OP_SBC) ? cin : 1'b0;
  assign sum9      = {1'b0, a} + {1'b0, b} + {8'd0, carry_t};
  assign sum_half  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_t};
  assign diff9     = {1'b0, a} - {1'b0, b} - {8'd0, sub_t};
  assign diff_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_t};
  assign inc_r     = a + 8'd1;
  assign dec_r     = a - 8'd1;

  // decimal adjust
  always_comb begin
    daa_adj = 8'd0;
    daa_c   = 1'b0;
    if (hin || (!nin && (a[3:0] > DAA_NIB_MAX))) begin
      daa_adj = DAA_ADJ_LO;
    end
    if (cin || (!nin && (a > DAA_LIMIT))) begin
      daa_adj = daa_adj | DAA_ADJ_HI;
      daa_c   = 1'b1;
    end
  end
  assign daa_r = nin ? (a - daa_adj) : (a + daa_adj);

  assign bit_mask = 8'd1 << alu_in.bit_index;

  // operation select
  always_comb begin
    res = a;
    flg = fl;
    wr  = 1'b1;
    case (alu_in.op)
      OP_ADD, OP_ADC: begin
        res = sum9[7:0];
        flg = {(res == 8'd0), 1'b0, sum_half[4], sum9[8]};
      end
      OP_SUB, OP_SBC: begin
        res = diff9[7:0];
        flg = {(res == 8'd0), 1'b1, diff_half[4], diff9[8]};
      end
      OP_CP: begin
        wr  = 1'b0;
        flg = {(diff9[7:0] == 8'd0), 1'b1, diff_half[4], diff9[8]};
      end
      OP_AND: begin
        res = a & b;
        flg = {(res == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        res = a ^ b;
        flg = {(res == 8'd0), 3'b000};
      end
      OP_OR: begin
        res = a | b;
        flg = {(res == 8'd0), 3'b000};
      end
      OP_INC: begin
        res = inc_r;
        flg = {(res == 8'd0), 1'b0, (res[3:0] == 4'h0), cin};
      end
      OP_DEC: begin
        res = dec_r;
        flg = {(res == 8'd0), 1'b1, (res[3:0] == 4'hF), cin};
      end
      OP_DAA: begin
        res = daa_r;
        flg = {(res == 8'd0), nin, 1'b0, daa_c};
      end
      OP_CPL: begin
        res = ~a;
        flg = {zin, 1'b1, 1'b1, cin};
      end
      OP_SCF: begin
        wr  = 1'b0;
        flg = {zin, 1'b0, 1'b0, 1'b1};
      end
      OP_CCF: begin
        wr  = 1'b0;
        flg = {zin, 1'b0, 1'b0, ~cin};
      end
      // accumulator rotates always clear z
      OP_RLCA: begin
        res = {a[6:0], a[7]};
        flg = {3'b000, a[7]};
      end
      OP_RRCA: begin
        res = {a[0], a[7:1]};
        flg = {3'b000, a[0]};
      end
      OP_RLA: begin
        res = {a[6:0], cin};
        flg = {3'b000, a[7]};
      end
      OP_RRA: begin
        res = {cin, a[7:1]};
        flg = {3'b000, a[0]};
      end
      OP_RLC: begin
        res = {a[6:0], a[7]};
        flg = {(res == 8'd0), 2'b00, a[7]};
      end
      OP_RRC: begin
        res = {a[0], a[7:1]};
        flg = {(res == 8'd0), 2'b00, a[0]};
      end
      OP_RL: begin
        res = {a[6:0], cin};
        flg = {(res == 8'd0), 2'b00, a[7]};
      end
      OP_RR: begin
        res = {cin, a[7:1]};
        flg = {(res == 8'd0), 2'b00, a[0]};
      end
      OP_SLA: begin
        res = {a[6:0], 1'b0};
        flg = {(res == 8'd0), 2'b00, a[7]};
      end
      OP_SRA: begin
        res = {a[7], a[7:1]};
        flg = {(res == 8'd0), 2'b00, a[0]};
      end
      OP_SWAP: begin
        res = {a[3:0], a[7:4]};
        flg = {(res == 8'd0), 3'b000};
      end
      OP_SRL: begin
        res = {1'b0, a[7:1]};
        flg = {(res == 8'd0), 2'b00, a[0]};
      end
      OP_BIT: begin
        wr  = 1'b0;
        flg = {((a & bit_mask) == 8'd0), 1'b0, 1'b1, cin};
      end
      OP_RES: begin
        res = a & ~bit_mask;
      end
      OP_SET: begin
        res = a | bit_mask;
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  assign alu_out.result       = res;
  assign alu_out.flags_out    = flg;
  assign alu_out.write_result = wr;

endmodule

// ===== tb/sv/tb_handheld_cpu_alu_8bit_top.sv =====
`timescale 1ns / 100ps

module tb_handheld_cpu_alu_8bit_top;
  import hcalu_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 10;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  alu_in_t  in_data = '0;
  logic     in_stall;
  logic     out_valid;
  alu_out_t out_data;
  logic     out_stall = 1'b0;

  // results still owed by the block, oldest first
  alu_out_t expected_results[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;

  // sender and receiver behavior knobs
  bit no_gaps = 1'b0;
  bit stall_quiet = 1'b0;
  bit hold_req = 1'b0;

  handheld_cpu_alu_8bit_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // flag nibble builder
  function automatic logic [3:0] make_flags(logic z, logic n, logic h, logic c);
    logic [3:0] f;
    f = '0;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

  // expected alu result for one operation
  function automatic alu_out_t predict_alu(alu_in_t x);
    alu_out_t   y;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    logic [7:0] adj;
    logic [8:0] wide;
    logic [4:0] nib;
    logic [3:0] f;
    logic       zin;
    logic       nin;
    logic       hin;
    logic       cin;
    logic       t;
    logic       cf;
    logic       wr;
    a   = x.operand_a;
    b   = x.operand_b;
    zin = x.flags_in[FLAG_Z];
    nin = x.flags_in[FLAG_N];
    hin = x.flags_in[FLAG_H];
    cin = x.flags_in[FLAG_C];
    r   = a;
    f   = x.flags_in;
    wr  = 1'b1;
    case (x.op)
      OP_ADD, OP_ADC: begin
        t    = (x.op == OP_ADC) ? cin : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + t;
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + t;
        r    = wide[7:0];
        f    = make_flags(r == 8'h00, 1'b0, nib[4], wide[8]);
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // borrow shows up as the sign bit of the widened difference
        t    = (x.op == OP_SBC) ? cin : 1'b0;
        wide = {1'b0, a} - {1'b0, b} - t;
        nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - t;
        r    = wide[7:0];
        f    = make_flags(r == 8'h00, 1'b1, nib[4], wide[8]);
        if (x.op == OP_CP) begin
          r  = a;
          wr = 1'b0;
        end
      end
      OP_AND: begin
        r = a & b;
        f = make_flags(r == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      OP_XOR: begin
        r = a ^ b;
        f = make_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_OR: begin
        r = a | b;
        f = make_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_INC: begin
        r = a + 8'd1;
        f = make_flags(r == 8'h00, 1'b0, r[3:0] == 4'h0, cin);
      end
      OP_DEC: begin
        r = a - 8'd1;
        f = make_flags(r == 8'h00, 1'b1, r[3:0] == 4'hF, cin);
      end
      OP_DAA: begin
        adj = '0;
        cf  = 1'b0;
        if (hin || (!nin && a[3:0] > DAA_NIB_MAX)) adj = DAA_ADJ_LO;
        if (cin || (!nin && a > DAA_LIMIT)) begin
          adj = adj | DAA_ADJ_HI;
          cf  = 1'b1;
        end
        r = nin ? (a - adj) : (a + adj);
        f = make_flags(r == 8'h00, nin, 1'b0, cf);
      end
      OP_CPL: begin
        r = ~a;
        f = make_flags(zin, 1'b1, 1'b1, cin);
      end
      OP_SCF: begin
        wr = 1'b0;
        f  = make_flags(zin, 1'b0, 1'b0, 1'b1);
      end
      OP_CCF: begin
        wr = 1'b0;
        f  = make_flags(zin, 1'b0, 1'b0, ~cin);
      end
      // accumulator rotates always clear z, prefixed ones test the result
      OP_RLCA, OP_RLC: begin
        r = {a[6:0], a[7]};
        f = make_flags((x.op == OP_RLC) && r == 8'h00, 1'b0, 1'b0, a[7]);
      end
      OP_RRCA, OP_RRC: begin
        r = {a[0], a[7:1]};
        f = make_flags((x.op == OP_RRC) && r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      OP_RLA, OP_RL: begin
        r = {a[6:0], cin};
        f = make_flags((x.op == OP_RL) && r == 8'h00, 1'b0, 1'b0, a[7]);
      end
      OP_RRA, OP_RR: begin
        r = {cin, a[7:1]};
        f = make_flags((x.op == OP_RR) && r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      OP_SLA: begin
        r = {a[6:0], 1'b0};
        f = make_flags(r == 8'h00, 1'b0, 1'b0, a[7]);
      end
      OP_SRA: begin
        r = {a[7], a[7:1]};
        f = make_flags(r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      OP_SWAP: begin
        r = {a[3:0], a[7:4]};
        f = make_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_SRL: begin
        r = {1'b0, a[7:1]};
        f = make_flags(r == 8'h00, 1'b0, 1'b0, a[0]);
      end
      OP_BIT: begin
        wr = 1'b0;
        f  = make_flags(!a[x.bit_index], 1'b0, 1'b1, cin);
      end
      OP_RES: r = a & ~(8'd1 << x.bit_index);
      OP_SET: r = a | (8'd1 << x.bit_index);
      // unused codes do nothing and write nothing
      default: wr = 1'b0;
    endcase
    y.result       = r;
    y.flags_out    = f;
    y.write_result = wr;
    return y;
  endfunction

  function automatic alu_in_t make_item(logic [4:0] op, logic [7:0] a, logic [7:0] b,
                                        logic [2:0] bi, logic [3:0] fl);
    alu_in_t x;
    x.op        = op;
    x.operand_a = a;
    x.operand_b = b;
    x.bit_index = bi;
    x.flags_in  = fl;
    return x;
  endfunction

  // operand byte, leaning on carry and bcd boundaries now and then
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [8] = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h99, 8'h9A, 8'h80, 8'h7F};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  // idle cycles before the next transaction: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // offer one transaction and wait until the block takes it
  task automatic send_op(alu_in_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_alu(item));
  endtask

  // every defined operation once, fields at their extremes
  task automatic test_each_op();
    op_t        code;
    logic [7:0] a;
    int         i;
    code = code.first();
    i = 0;
    do begin
      a = (i % 4 == 0) ? 8'h00 : (i % 4 == 1) ? 8'hFF : (i % 4 == 2) ? 8'h80 : 8'h01;
      send_op(make_item(code, a, ~a, 3'(i), (i % 2) ? 4'hF : 4'h0));
      code = code.next();
      i++;
    end while (code != code.first());
  endtask

  // unused codes, decimal adjust after addition and subtraction, carry chains
  task automatic test_corner_cases();
    logic [3:0] fl_nc;
    fl_nc = make_flags(1'b0, 1'b1, 1'b0, 1'b1);
    for (int c = int'(OP_SET) + 1; c < (1 << $bits(op_t)); c++)
      send_op(make_item(5'(c), 8'hA5, 8'h5A, 3'd7, 4'hF));
    send_op(make_item(OP_DAA, 8'h00, 8'h00, 3'd0, fl_nc));
    send_op(make_item(OP_DAA, 8'h9A, 8'h00, 3'd0, 4'h0));
    send_op(make_item(OP_DAA, 8'h0F, 8'h00, 3'd0, make_flags(1'b0, 1'b1, 1'b1, 1'b0)));
    send_op(make_item(OP_ADC, 8'hFF, 8'h00, 3'd0, make_flags(1'b0, 1'b0, 1'b0, 1'b1)));
    send_op(make_item(OP_SBC, 8'h00, 8'hFF, 3'd0, make_flags(1'b0, 1'b0, 1'b0, 1'b1)));
    send_op(make_item(OP_ADD, 8'h0F, 8'h01, 3'd0, 4'h0));
  endtask

  // random operations, unused codes included, with idling on both sides
  task automatic test_random_ops(int count);
    repeat (count)
      send_op(make_item(5'($urandom_range(0, 31)), pick_byte(), pick_byte(),
                        3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))));
  endtask

  // full rate stretch with no idling anywhere
  task automatic test_back_to_back(int count);
    no_gaps     = 1'b1;
    stall_quiet = 1'b1;
    test_random_ops(count);
    no_gaps     = 1'b0;
    stall_quiet = 1'b0;
  endtask

  // receiver holds off for a long stretch while the sender keeps pushing
  task automatic test_backpressure(int count);
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    test_random_ops(count);
    no_gaps  = 1'b0;
  endtask

  // receiver stall pattern
  always begin : out_stall_gen
    int unsigned run_len;
    int unsigned p;
    logic        stall_val;
    @(posedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
    end else begin
      p = $urandom_range(0, 99);
      if (stall_quiet || p < 55) begin
        stall_val = 1'b0;
        run_len   = $urandom_range(1, 20);
      end else if (p < 92) begin
        stall_val = 1'b1;
        run_len   = $urandom_range(1, 3);
      end else begin
        stall_val = 1'b1;
        run_len   = $urandom_range(10, 40);
      end
      out_stall <= stall_val;
      repeat (run_len - 1) @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    alu_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transaction, actual result=%h flags=%h wr=%b",
                 $time, out_data.result, out_data.flags_out, out_data.write_result);
      end else begin
        want = expected_results.pop_front();
        if (out_data.result !== want.result || out_data.flags_out !== want.flags_out ||
            out_data.write_result !== want.write_result) begin
          mismatch_count++;
          $display("%0t: expected result=%h flags=%h wr=%b, actual result=%h flags=%h wr=%b",
                   $time, want.result, want.flags_out, want.write_result,
                   out_data.result, out_data.flags_out, out_data.write_result);
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // test sequence
  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_each_op();
    test_corner_cases();
    test_random_ops(1150);
    test_back_to_back(120);
    test_backpressure(100);
    test_random_ops(60);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
